### sv/lcdseq_pkg.sv
// Shared types, codes and constant tables for the character LCD write sequencer.
// No dependencies; the controller, datapath and top level import this package.
package lcdseq_pkg;

	localparam int unsigned IDX_W  = 5;   // segment index, up to 29 segments
	localparam int unsigned STEP_W = 4;   // nibble step within the init run
	localparam int unsigned HOLD_W = 17;
	localparam int unsigned WAIT_W = 16;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_CMD   = 2'd2;
	localparam logic [1:0] KIND_LIGHT = 2'd3;

	localparam logic [HOLD_W-1:0] POWER_WAIT_US     = 17'd15000;
	localparam logic [HOLD_W-1:0] BACKLIGHT_WAIT_US = 17'd25000;
	localparam logic [HOLD_W-1:0] PULSE_US          = 17'd1;
	localparam logic [WAIT_W-1:0] CMD_WAIT_US       = 16'd50;
	localparam logic [WAIT_W-1:0] CHAR_DELAY_RESET  = 16'd50;

	localparam logic [3:0] NIB_DISP_ON  = 4'hC;
	localparam logic [3:0] NIB_DISP_OFF = 4'h8;

	localparam logic [IDX_W-1:0] INIT_LAST_IDX  = 5'd28;
	localparam logic [IDX_W-1:0] CHAR_LAST_IDX  = 5'd3;
	localparam logic [IDX_W-1:0] CMD_LAST_IDX   = 5'd1;
	localparam logic [IDX_W-1:0] LIGHT_LAST_IDX = 5'd4;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;   // latch an accepted request
		logic emit;   // produce the next segment into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a segment this cycle
		logic seg_last;   // current segment closes the request
	} dp_status_t;

	function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
		logic [3:0] n;
		unique case (step)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5, 4'd7:       n = 4'h8;
			4'd9:             n = 4'h1;
			4'd11:            n = 4'h6;
			4'd13:            n = 4'hC;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
		logic [WAIT_W-1:0] w;
		unique case (step)
			4'd0:                      w = 16'd4100;
			4'd1:                      w = 16'd100;
			4'd3, 4'd5, 4'd7, 4'd11,
			4'd13:                     w = 16'd50;
			4'd9:                      w = 16'd2000;
			default:                   w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

### sv/lcdseq_req_if.sv
// Request channel: valid/ready handshake carrying one LCD request.
// Depends on nothing.
interface lcdseq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [15:0] delay_us;

	modport source (output valid, kind, value, delay_us, input ready);
	modport sink   (input valid, kind, value, delay_us, output ready);
endinterface

### sv/lcdseq_seg_if.sv
// Segment channel: valid/ready handshake carrying one timed pin-state segment.
// Depends on nothing.
interface lcdseq_seg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  data_nibble;
	logic        reg_select;
	logic        enable;
	logic        backlight;
	logic [16:0] hold_us;
	logic        last;

	modport source (output valid, data_nibble, reg_select, enable, backlight, hold_us, last,
		input ready);
	modport sink   (input valid, data_nibble, reg_select, enable, backlight, hold_us, last,
		output ready);
endinterface

### sv/lcdseq_ctrl.sv
// Controller FSM: accepts a request, then steps the datapath one segment a beat while the output register is free.
// Depends on lcdseq_pkg.
module lcdseq_ctrl
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.out_free && status.seg_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.emit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

### sv/lcdseq_dpath.sv
// Datapath: request latch, segment index, pin state, segment decode, output register.
// Depends on lcdseq_pkg.
module lcdseq_dpath
	import lcdseq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  logic [1:0]        in_kind,
	input  logic [7:0]        in_value,
	input  logic [WAIT_W-1:0] in_delay_us,
	input  logic              cfg_we,
	input  logic [WAIT_W-1:0] cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        out_data_nibble,
	output logic              out_reg_select,
	output logic              out_enable,
	output logic              out_backlight,
	output logic [HOLD_W-1:0] out_hold_us,
	output logic              out_last
);

	logic [1:0]        kind_q;
	logic [7:0]        value_q;
	logic [WAIT_W-1:0] delay_q;
	logic [WAIT_W-1:0] char_delay_q;
	logic [IDX_W-1:0]  idx_q;
	logic [3:0]        pins_q;
	logic              rs_q;
	logic              light_q;
	logic              out_valid_q;

	logic [3:0]        nib_q;
	logic              rs_out_q;
	logic              en_q;
	logic              bl_q;
	logic [HOLD_W-1:0] hold_q;
	logic              last_q;

	// segment decode
	logic              is_nib;
	logic              pulse;
	logic [3:0]        nib;
	logic              rs_new;
	logic [WAIT_W-1:0] wait_us;
	logic [HOLD_W-1:0] fixed_hold;
	logic              seg_last;
	logic [IDX_W-1:0]  init_j;
	logic [HOLD_W-1:0] hold;

	assign init_j = idx_q - 5'd1;

	always_comb begin
		is_nib     = 1'b1;
		pulse      = ~idx_q[0];
		nib        = 4'h0;
		rs_new     = 1'b0;
		wait_us    = '0;
		fixed_hold = POWER_WAIT_US;
		seg_last   = 1'b0;
		unique case (kind_q)
			KIND_INIT: begin
				// leading power-on wait, then 14 nibble writes
				seg_last = (idx_q == INIT_LAST_IDX);
				if (idx_q == '0) begin
					is_nib = 1'b0;
				end else begin
					pulse   = ~init_j[0];
					nib     = init_nibble(init_j[STEP_W:1]);
					wait_us = init_wait(init_j[STEP_W:1]);
				end
			end
			KIND_CHAR: begin
				rs_new   = 1'b1;
				nib      = idx_q[1] ? value_q[3:0] : value_q[7:4];
				wait_us  = idx_q[1] ? char_delay_q : '0;
				seg_last = (idx_q == CHAR_LAST_IDX);
			end
			KIND_CMD: begin
				nib      = value_q[3:0];
				wait_us  = delay_q;
				seg_last = (idx_q == CMD_LAST_IDX);
			end
			KIND_LIGHT: begin
				seg_last = (idx_q == LIGHT_LAST_IDX);
				if (idx_q == LIGHT_LAST_IDX) begin
					is_nib     = 1'b0;
					fixed_hold = BACKLIGHT_WAIT_US;
				end else begin
					nib     = idx_q[1] ? (light_q ? NIB_DISP_ON : NIB_DISP_OFF) : 4'h0;
					wait_us = idx_q[1] ? CMD_WAIT_US : '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!is_nib) begin
			hold = fixed_hold;
		end else if (pulse) begin
			hold = PULSE_US;
		end else begin
			hold = {1'b0, wait_us} + PULSE_US;
		end
	end

	assign status.out_free = ~out_valid_q | out_ready;
	assign status.seg_last = seg_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_delay_q <= CHAR_DELAY_RESET;
			idx_q        <= '0;
			pins_q       <= '0;
			rs_q         <= 1'b0;
			light_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) char_delay_q <= cfg_data;
			if (cmd.load) begin
				idx_q <= '0;
				if (in_kind == KIND_LIGHT) light_q <= in_value[0];
			end else if (cmd.emit) begin
				idx_q <= idx_q + 5'd1;
				if (is_nib) begin
					pins_q <= nib;
					rs_q   <= rs_new;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			value_q <= in_value;
			delay_q <= in_delay_us;
		end
		if (cmd.emit) begin
			nib_q    <= is_nib ? nib : pins_q;
			rs_out_q <= is_nib ? rs_new : rs_q;
			en_q     <= is_nib & pulse;
			bl_q     <= light_q;
			hold_q   <= hold;
			last_q   <= seg_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data_nibble = nib_q;
	assign out_reg_select  = rs_out_q;
	assign out_enable      = en_q;
	assign out_backlight   = bl_q;
	assign out_hold_us     = hold_q;
	assign out_last        = last_q;

endmodule

### sv/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD 4-bit write sequencer: controller plus datapath.
// Depends on lcdseq_pkg, lcdseq_req_if, lcdseq_seg_if, lcdseq_ctrl, lcdseq_dpath.
//
//   port      dir  beat contents
//   req       in   kind, value, delay_us
//   seg       out  data_nibble, reg_select, enable, backlight, hold_us, last
//   cfg_we    in   cfg_data -> char_delay_us (no read-back)
//
// A request is accepted in the idle state, then yields one segment per cycle while seg.ready
// is high: 29 segments for init, 4 per character, 2 per command nibble, 5 for
// backlight. The segment counter in the datapath, checked against the last index
// per kind, ends the request. Stalls on seg hold the output register and the counter.
// The next request is taken once the last segment sits in the output register.
// Reset: pins, RS and backlight low, char_delay_us = 50.
module char_lcd_nibble_write_sequencer
	import lcdseq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	lcdseq_req_if.sink         req,
	lcdseq_seg_if.source       seg,
	input  logic               cfg_we,
	input  logic [WAIT_W-1:0]  cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	lcdseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdseq_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_kind         (req.kind),
		.in_value        (req.value),
		.in_delay_us     (req.delay_us),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.out_valid       (seg.valid),
		.out_ready       (seg.ready),
		.out_data_nibble (seg.data_nibble),
		.out_reg_select  (seg.reg_select),
		.out_enable      (seg.enable),
		.out_backlight   (seg.backlight),
		.out_hold_us     (seg.hold_us),
		.out_last        (seg.last)
	);

endmodule
